// ===== hdl/sorted_deadline_timer_queue_unit_assert.svh =====
// Assertion macros for the sorted deadline timer queue.
// Expects signals clk and arst_n in the scope where the macros are used.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SDTQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdtq assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SDTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdtq assertion failed");

`endif

// ===== hdl/sdtq_pkg.sv =====
// Shared types, constants and codes for the sorted deadline timer queue.
// No dependencies.
`default_nettype none
package sdtq_pkg;
	localparam int DEPTH       = 16;
	localparam int ID_WIDTH    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int DELAY_W     = 24;
	localparam int TIME_W      = 32;
	localparam int OUT_ID_W    = 16;

	typedef logic [ID_WIDTH-1:0] ident_t;
	typedef logic [TIME_W-1:0]   deadline_t;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		EV_ADDED     = 3'd0,
		EV_IMMEDIATE = 3'd1,
		EV_EXPIRED   = 3'd2,
		EV_DELETED   = 3'd3,
		EV_FULL      = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		MV_HOLD  = 3'd0,
		MV_EVAL  = 3'd1,
		MV_LEFT  = 3'd2,
		MV_RIGHT = 3'd3,
		MV_NEW   = 3'd4
	} move_t;

	typedef struct packed {
		logic      valid;
		logic      cond;
		deadline_t dl;
		ident_t    id;
	} cell_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [DELAY_W-1:0] delay;
		ident_t             target;
		deadline_t          now;
	} bcast_t;
endpackage
`default_nettype wire

// ===== hdl/sdtq_cell.sv =====
// One cell of the sorted timer chain: a deadline, an id, a valid bit and a test bit.
// Depends on sdtq_pkg.
`default_nettype none
module sdtq_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sdtq_pkg::move_t      move,
	input  wire sdtq_pkg::bcast_t     bcast,
	input  wire sdtq_pkg::deadline_t  new_dl,
	input  wire sdtq_pkg::ident_t     new_id,
	input  wire sdtq_pkg::cell_t      left,
	input  wire sdtq_pkg::cell_t      right,
	output sdtq_pkg::cell_t           state
);
	logic                valid_q;
	logic                cond_q;
	sdtq_pkg::deadline_t dl_q;
	sdtq_pkg::ident_t    id_q;
	sdtq_pkg::deadline_t diff;
	logic                cond_d;

	assign diff = dl_q - bcast.now;

	always_comb begin
		case (bcast.opcode)
			sdtq_pkg::OP_ADD:  cond_d = valid_q
				&& (diff <= sdtq_pkg::TIME_W'(bcast.delay));
			sdtq_pkg::OP_DEL:  cond_d = valid_q && (id_q == bcast.target);
			sdtq_pkg::OP_TICK: cond_d = valid_q
				&& ((diff == '0) || diff[sdtq_pkg::TIME_W-1]);
			default:           cond_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cond_q  <= 1'b0;
		end else begin
			case (move)
				sdtq_pkg::MV_EVAL: cond_q <= cond_d;
				sdtq_pkg::MV_LEFT: begin
					valid_q <= left.valid;
					cond_q  <= left.cond;
				end
				sdtq_pkg::MV_RIGHT: begin
					valid_q <= right.valid;
					cond_q  <= right.cond;
				end
				sdtq_pkg::MV_NEW: begin
					valid_q <= 1'b1;
					cond_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (move)
			sdtq_pkg::MV_LEFT: begin
				dl_q <= left.dl;
				id_q <= left.id;
			end
			sdtq_pkg::MV_RIGHT: begin
				dl_q <= right.dl;
				id_q <= right.id;
			end
			sdtq_pkg::MV_NEW: begin
				dl_q <= new_dl;
				id_q <= new_id;
			end
			default: ;
		endcase
	end

	assign state = '{valid: valid_q, cond: cond_q, dl: dl_q, id: id_q};
endmodule
`default_nettype wire

// ===== hdl/sorted_deadline_timer_queue_unit.sv =====
// Sorted deadline timer queue: an add or delete is tested in ST_EVAL and applied in ST_APPLY.
// A tick is tested in ST_EVAL, then fires one expired timer per unstalled cycle, up to 16.
// The next command is taken in the cycle after the last result is registered.
// Reset clears the valid bits, the millisecond count and the id counter; no clearing pass.
`default_nettype none
module sorted_deadline_timer_queue_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [23:0] delay_ms,
	input  wire logic [15:0] target_id,
	output logic             evt_valid,
	input  wire logic        evt_stall,
	output logic [2:0]       event_kind,
	output logic [15:0]      timer_ident,
	output logic             found,
	output logic             last
);
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t                     state_q;
	sdtq_pkg::bcast_t           bcast_q;
	sdtq_pkg::ident_t           next_id_q;
	logic [sdtq_pkg::CNT_W-1:0] fire_cnt_q;
	logic                       evt_valid_q;
	logic [2:0]                 kind_q;
	logic [15:0]                ident_q;
	logic                       found_q;
	logic                       last_q;

	sdtq_pkg::cell_t            cells [sdtq_pkg::DEPTH];
	sdtq_pkg::move_t            moves [sdtq_pkg::DEPTH];
	logic [sdtq_pkg::DEPTH-1:0] cond_vec;
	logic [sdtq_pkg::DEPTH-1:0] valid_vec;
	logic [sdtq_pkg::DEPTH-1:0] ins_at;
	logic [sdtq_pkg::DEPTH-1:0] ins_left;
	logic [sdtq_pkg::DEPTH-1:0] rm_at;
	sdtq_pkg::deadline_t        new_dl;
	sdtq_pkg::ident_t           id_inc;
	sdtq_pkg::ident_t           id_fresh;
	logic                       accept;
	logic                       out_free;
	logic                       full;
	logic                       emit;
	logic                       done;
	logic                       fire;
	logic                       fire_last;
	logic [2:0]                 emit_kind;
	logic [15:0]                emit_ident;
	logic                       emit_found;
	logic                       emit_last;

	genvar g;
	generate
		for (g = 0; g < sdtq_pkg::DEPTH; g++) begin : g_cell
			sdtq_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.move   (moves[g]),
				.bcast  (bcast_q),
				.new_dl (new_dl),
				.new_id (id_fresh),
				.left   ((g == 0) ? sdtq_pkg::cell_t'('0) : cells[(g == 0) ? 0 : g - 1]),
				.right  ((g == sdtq_pkg::DEPTH - 1) ? sdtq_pkg::cell_t'('0)
					: cells[(g == sdtq_pkg::DEPTH - 1) ? g : g + 1]),
				.state  (cells[g])
			);
			assign cond_vec[g]  = cells[g].cond;
			assign valid_vec[g] = cells[g].valid;
		end
	endgenerate

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign out_free  = !evt_valid_q || !evt_stall;
	assign full      = valid_vec[sdtq_pkg::DEPTH-1];
	assign new_dl    = bcast_q.now + sdtq_pkg::TIME_W'(bcast_q.delay);
	assign id_inc    = next_id_q + sdtq_pkg::ident_t'(1);
	assign id_fresh  = (id_inc == '0) ? sdtq_pkg::ident_t'(1) : id_inc;

	// The insert point follows the run of leading cells that stay in front.
	assign ins_at   = ~(cond_vec & ~(cond_vec + sdtq_pkg::DEPTH'(1)));
	assign ins_left = {ins_at[sdtq_pkg::DEPTH-2:0], 1'b0};
	// Removal shifts every cell from the first match onward.
	assign rm_at    = cond_vec | (~cond_vec + sdtq_pkg::DEPTH'(1));

	assign fire      = (state_q == ST_APPLY) && (bcast_q.opcode == sdtq_pkg::OP_TICK)
		&& cond_vec[0] && out_free;
	assign fire_last = (fire_cnt_q == sdtq_pkg::CNT_W'(sdtq_pkg::MAX_RESULTS - 1))
		|| !cond_vec[1];

	always_comb begin
		emit       = 1'b0;
		done       = 1'b0;
		emit_kind  = sdtq_pkg::EV_ADDED;
		emit_ident = '0;
		emit_found = 1'b0;
		emit_last  = 1'b1;
		for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
			moves[i] = sdtq_pkg::MV_HOLD;
		end
		case (state_q)
			ST_EVAL: begin
				for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
					moves[i] = sdtq_pkg::MV_EVAL;
				end
			end
			ST_APPLY: begin
				case (bcast_q.opcode)
					sdtq_pkg::OP_ADD: begin
						emit = out_free;
						done = out_free;
						if (bcast_q.delay == '0) begin
							emit_kind = sdtq_pkg::EV_IMMEDIATE;
						end else if (full) begin
							emit_kind = sdtq_pkg::EV_FULL;
						end else begin
							emit_kind  = sdtq_pkg::EV_ADDED;
							emit_ident = 16'(id_fresh);
							for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
								if (out_free && ins_left[i]) begin
									moves[i] = sdtq_pkg::MV_LEFT;
								end else if (out_free && ins_at[i]) begin
									moves[i] = sdtq_pkg::MV_NEW;
								end
							end
						end
					end
					sdtq_pkg::OP_DEL: begin
						emit       = out_free;
						done       = out_free;
						emit_kind  = sdtq_pkg::EV_DELETED;
						emit_ident = 16'(bcast_q.target);
						emit_found = |cond_vec;
						for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
							if (out_free && rm_at[i]) begin
								moves[i] = sdtq_pkg::MV_RIGHT;
							end
						end
					end
					sdtq_pkg::OP_TICK: begin
						emit       = fire;
						done       = !cond_vec[0] || (fire && fire_last);
						emit_kind  = sdtq_pkg::EV_EXPIRED;
						emit_ident = 16'(cells[0].id);
						emit_last  = fire_last;
						for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
							if (fire) begin
								moves[i] = sdtq_pkg::MV_RIGHT;
							end
						end
					end
					default: done = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bcast_q     <= '0;
			next_id_q   <= '0;
			fire_cnt_q  <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				bcast_q.opcode <= opcode;
				bcast_q.delay  <= delay_ms;
				bcast_q.target <= sdtq_pkg::ID_WIDTH'(target_id);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_EVAL;
						fire_cnt_q <= '0;
						if (opcode == sdtq_pkg::OP_TICK) begin
							bcast_q.now <= bcast_q.now + sdtq_pkg::TIME_W'(1);
						end
					end
				end
				ST_EVAL: state_q <= ST_APPLY;
				ST_APPLY: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				fire_cnt_q <= fire_cnt_q + sdtq_pkg::CNT_W'(1);
			end
			if (emit && (bcast_q.opcode == sdtq_pkg::OP_ADD) && (bcast_q.delay != '0)
				&& !full) begin
				next_id_q <= id_fresh;
			end
			if (emit) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= emit_kind;
			ident_q <= emit_ident;
			found_q <= emit_found;
			last_q  <= emit_last;
		end
	end

	assign evt_valid   = evt_valid_q;
	assign event_kind  = kind_q;
	assign timer_ident = ident_q;
	assign found       = found_q;
	assign last        = last_q;

	`include "sorted_deadline_timer_queue_unit_assert.svh"

	`SDTQ_ASSERT_NOW(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
	`SDTQ_ASSERT_NOW(a_result_from_apply, $rose(evt_valid), $past(state_q == ST_APPLY))
	`SDTQ_ASSERT_NEXT(a_time_only_on_transfer, state_q != ST_IDLE, $stable(bcast_q.now))
	`SDTQ_ASSERT_NEXT(a_fire_takes_head, fire && cells[1].valid, $past(cells[1].id) == cells[0].id)
endmodule
`default_nettype wire

// ===== tb/sdtq_checker.sv =====
// Checker for the sorted deadline timer queue: watches both channels, predicts every event
// from the accepted commands and compares each accepted event field by field.
// Depends on sdtq_pkg for the table size, the result cap and the opcode and event codes.
`default_nettype none
module sdtq_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire logic        cmd_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [23:0] delay_ms,
	input  wire logic [15:0] target_id,
	input  wire logic        evt_valid,
	input  wire logic        evt_stall,
	input  wire logic [2:0]  event_kind,
	input  wire logic [15:0] timer_ident,
	input  wire logic        found,
	input  wire logic        last,
	output int               failures,
	output int               outstanding
);
	import sdtq_pkg::*;

	typedef struct packed {
		event_t      kind;
		logic [15:0] ident;
		logic        found;
		logic        last;
	} timer_event_t;

	timer_event_t due_events[$];
	deadline_t    dl_tab[DEPTH];
	ident_t       id_tab[DEPTH];
	int           fill = 0;
	deadline_t    now_ms = '0;
	ident_t       last_id = '0;
	int           fail_count = 0;
	int           due_count = 0;

	assign failures = fail_count;
	assign outstanding = due_count;

	function automatic logic is_due(deadline_t dl, deadline_t now);
		deadline_t diff;
		diff = dl - now;
		return (diff == '0) || diff[TIME_W-1];
	endfunction

	task automatic note_event(event_t kind, logic [15:0] ident, logic fnd, logic lst);
		timer_event_t ev;
		ev.kind = kind;
		ev.ident = ident;
		ev.found = fnd;
		ev.last = lst;
		due_events.push_back(ev);
	endtask

	task automatic drop_entry(int pos);
		int i;
		for (i = pos; i + 1 < fill; i++) begin
			dl_tab[i] = dl_tab[i + 1];
			id_tab[i] = id_tab[i + 1];
		end
		fill--;
	endtask

	task automatic apply_timer_command(logic [1:0] op, logic [23:0] delay,
			logic [15:0] target);
		ident_t    nid;
		ident_t    tid;
		deadline_t gap;
		int        pos;
		int        k;
		logic      hit;
		logic      stop;
		case (op)
			OP_ADD: begin
				if (delay == '0) begin
					note_event(EV_IMMEDIATE, 16'd0, 1'b0, 1'b1);
				end else if (fill >= DEPTH) begin
					note_event(EV_FULL, 16'd0, 1'b0, 1'b1);
				end else begin
					nid = last_id + ident_t'(1);
					if (nid == '0)
						nid = ident_t'(1);
					last_id = nid;
					// New entries go behind every entry that is due no later.
					pos = 0;
					stop = 1'b0;
					while (pos < fill && !stop) begin
						gap = dl_tab[pos] - now_ms;
						if (gap <= {8'd0, delay})
							pos++;
						else
							stop = 1'b1;
					end
					for (k = fill; k > pos; k--) begin
						dl_tab[k] = dl_tab[k - 1];
						id_tab[k] = id_tab[k - 1];
					end
					dl_tab[pos] = now_ms + {8'd0, delay};
					id_tab[pos] = nid;
					fill++;
					note_event(EV_ADDED, nid, 1'b0, 1'b1);
				end
			end
			OP_DEL: begin
				tid = target;
				hit = 1'b0;
				for (pos = 0; pos < fill; pos++) begin
					if (!hit && id_tab[pos] == tid) begin
						drop_entry(pos);
						hit = 1'b1;
					end
				end
				note_event(EV_DELETED, tid, hit, 1'b1);
			end
			OP_TICK: begin
				now_ms = now_ms + deadline_t'(1);
				k = 0;
				while (k < MAX_RESULTS && fill > 0 && is_due(dl_tab[0], now_ms)) begin
					tid = id_tab[0];
					drop_entry(0);
					k++;
					note_event(EV_EXPIRED, tid, 1'b0,
						!(k < MAX_RESULTS && fill > 0 && is_due(dl_tab[0], now_ms)));
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		timer_event_t want;
		if (arst_n) begin
			if (evt_valid && !evt_stall) begin
				if (due_events.size() == 0) begin
					$error("event transfer with no event expected: kind %0d, ident %0d",
						event_kind, timer_ident);
					fail_count++;
				end else begin
					want = due_events.pop_front();
					if (event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
						fail_count++;
					end
					if (timer_ident !== want.ident) begin
						$error("timer_ident: expected %0d, got %0d", want.ident, timer_ident);
						fail_count++;
					end
					if (found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, found);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				apply_timer_command(opcode, delay_ms, target_id);
			due_count = due_events.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Top of the timer queue testbench: drives commands, stalls the event channel and gives
// the verdict. Depends on sdtq_pkg, the sorted_deadline_timer_queue_unit RTL and sdtq_checker.
`default_nettype none
module tb_top;
	import sdtq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  opcode = '0;
	logic [23:0] delay_ms = '0;
	logic [15:0] target_id = '0;
	logic        evt_valid;
	logic        evt_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [15:0] timer_ident;
	logic        found;
	logic        last;
	int          failures;
	int          outstanding;

	logic        calm = 1'b0;
	int          stall_left = 0;
	int          cycle_count = 0;
	logic [15:0] recent_ids[8] = '{default: '0};
	logic [2:0]  recent_wr = '0;

	sorted_deadline_timer_queue_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.delay_ms(delay_ms),
		.target_id(target_id),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.event_kind(event_kind),
		.timer_ident(timer_ident),
		.found(found),
		.last(last)
	);

	sdtq_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.delay_ms(delay_ms),
		.target_id(target_id),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.event_kind(event_kind),
		.timer_ident(timer_ident),
		.found(found),
		.last(last),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			evt_stall <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 15);
			evt_stall <= 1'b1;
		end
	end

	// Ids from recent adds give deletes a fair chance to hit a live timer.
	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall && event_kind == EV_ADDED) begin
			recent_ids[recent_wr] <= timer_ident;
			recent_wr <= recent_wr + 3'd1;
		end
	end

	task automatic send_cmd(logic [1:0] op, logic [23:0] delay, logic [15:0] tgt);
		cmd_valid <= 1'b1;
		opcode <= op;
		delay_ms <= delay;
		target_id <= tgt;
		do @(posedge clk); while (cmd_stall);
		if (!calm && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_random_cmd();
		int          pick;
		int          sel;
		logic [23:0] delay;
		logic [15:0] tgt;
		pick = $urandom_range(0, 19);
		sel = $urandom_range(0, 19);
		delay = 24'($urandom);
		tgt = 16'($urandom);
		if (pick < 8) begin
			if (sel == 0)
				delay = '0;
			else if (sel == 1)
				delay = '1;
			else if (sel > 4)
				delay = 24'($urandom_range(1, 12));
			send_cmd(OP_ADD, delay, tgt);
		end else if (pick < 12) begin
			if (sel == 0)
				tgt = '0;
			else if (sel == 1)
				tgt = '1;
			else if (sel > 3)
				tgt = recent_ids[$urandom_range(0, 7)];
			send_cmd(OP_DEL, delay, tgt);
		end else if (pick < 19) begin
			send_cmd(OP_TICK, delay, tgt);
		end else begin
			send_cmd(OP_UNUSED, delay, tgt);
		end
	endtask

	initial begin
		int r;
		int j;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_TICK, 24'd0, 16'd0);
		send_cmd(OP_UNUSED, 24'd0, 16'd0);
		send_cmd(OP_ADD, 24'd0, 16'd0);
		send_cmd(OP_ADD, 24'hFFFFFF, 16'd0);
		send_cmd(OP_DEL, 24'd0, 16'd0);
		send_cmd(OP_DEL, 24'd0, 16'hFFFF);
		send_cmd(OP_DEL, 24'd0, 16'd1);
		// Sixteen equal deadlines fill the table and then expire on a single tick.
		for (j = 0; j < DEPTH; j++)
			send_cmd(OP_ADD, 24'd2, 16'd0);
		send_cmd(OP_ADD, 24'd5, 16'd0);
		send_cmd(OP_TICK, 24'd0, 16'd0);
		send_cmd(OP_TICK, 24'd0, 16'd0);

		for (r = 0; r < 84; r++) begin
			if (r == 70)
				calm <= 1'b1;
			send_random_cmd();
		end
		cmd_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected events never arrived", outstanding);
		if (failures == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
